/* hw/rtl/running_median_two_heaps_core_macros.svh */
// Assertion macros shared by the running median RTL
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define RMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmh assertion failed");

// implication checked in the following cycle
`define RMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmh assertion failed");

`endif

/* hw/rtl/rmh_pkg.sv */
//------------------------------------------------------------------------------
// rmh_pkg
// Shared constants and codes for the running median core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package rmh_pkg;
	localparam int unsigned HEAP_CAPACITY_DEF = 1024;
	localparam int unsigned VALUE_WIDTH_DEF   = 32;
	localparam int unsigned IN_VALUE_W        = 32;
	localparam int unsigned COUNT_W           = 11;
	localparam int unsigned STATUS_W          = 3;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MEDIAN   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

	// sift operation requested of a heap unit
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} heap_op_t;
endpackage

/* hw/rtl/rmh_heap.sv */
//------------------------------------------------------------------------------
// rmh_heap
// One binary heap held in a synchronous memory, sifted one level per step.
// Push sifts up from the new leaf, pop sifts down from the root.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_median_two_heaps_core_macros.svh"
module rmh_heap
	import rmh_pkg::*;
#(
	parameter int unsigned CAP   = HEAP_CAPACITY_DEF,
	parameter int unsigned VW    = VALUE_WIDTH_DEF,
	parameter bit          IS_MAX = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  heap_op_t               op,
	input  logic [VW-1:0]          din,
	input  logic                   clear,
	output logic                   done,
	output logic [VW-1:0]          dout,
	output logic [$clog2(CAP):0]   size
);
	localparam int unsigned AW = $clog2(CAP);
	localparam int unsigned SW = AW + 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_UPRD   = 8'b00000010,
		S_UPCMP  = 8'b00000100,
		S_ROOTRD = 8'b00001000,
		S_LASTRD = 8'b00010000,
		S_DNRDL  = 8'b00100000,
		S_DNRDR  = 8'b01000000,
		S_DNCMP  = 8'b10000000
	} hstate_t;

	hstate_t        state_q;
	logic [VW-1:0]  mem [CAP];
	logic [VW-1:0]  rdata_q;
	logic [VW-1:0]  v_q;
	logic [VW-1:0]  cl_q;
	logic [SW-1:0]  size_q;
	logic [SW-1:0]  i_q;
	logic [SW-1:0]  n_q;
	logic           done_q;
	logic [VW-1:0]  dout_q;

	// read port address and write controls
	logic [AW-1:0]  raddr;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [VW-1:0]  wdata;

	logic [SW-1:0]  parent;
	logic [SW:0]    lchild;
	logic [SW:0]    rchild;
	logic           before_pv;
	logic           before_rl;
	logic           before_cv;
	logic [VW-1:0]  best_c;
	logic [SW-1:0]  best_i;
	logic           has_r_q;
	logic           idle_start;

	function automatic logic goes_before(input logic [VW-1:0] a, input logic [VW-1:0] b);
		goes_before = IS_MAX ? (a > b) : (a < b);
	endfunction

	assign parent     = (i_q - SW'(1)) >> 1;
	assign lchild     = {i_q, 1'b1};
	assign rchild     = lchild + (SW+1)'(1);
	assign before_pv  = goes_before(v_q, rdata_q);
	assign before_rl  = has_r_q && goes_before(rdata_q, cl_q);
	assign best_c     = before_rl ? rdata_q : cl_q;
	assign best_i     = before_rl ? rchild[SW-1:0] : lchild[SW-1:0];
	assign before_cv  = goes_before(best_c, v_q);
	assign idle_start = start && (state_q == S_IDLE);

	// memory read address per state
	always_comb begin
		raddr = '0;
		case (state_q)
			S_IDLE:   raddr = '0;
			S_UPRD:   raddr = parent[AW-1:0];
			S_ROOTRD: raddr = n_q[AW-1:0];
			S_DNRDL:  raddr = lchild[AW-1:0];
			S_DNRDR:  raddr = rchild[AW-1:0];
			default:  raddr = '0;
		endcase
	end

	// synchronous memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// write decisions; a compare step writes the carried value or the one that moves past it
	always_comb begin
		we    = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = v_q;
		case (state_q)
			S_UPCMP: begin
				we = 1'b1;
				if (i_q != '0 && before_pv) begin
					wdata = rdata_q;
				end
			end
			S_DNCMP: begin
				we = 1'b1;
				if ((lchild < {1'b0, n_q}) && before_cv) begin
					wdata = best_c;
				end
			end
			default: we = 1'b0;
		endcase
	end

	// sift sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				size_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op)
							OP_PUSH: begin
								v_q     <= din;
								i_q     <= size_q;
								size_q  <= size_q + SW'(1);
								state_q <= (size_q == '0) ? S_UPCMP : S_UPRD;
							end
							OP_POP: begin
								n_q     <= size_q - SW'(1);
								size_q  <= size_q - SW'(1);
								state_q <= S_ROOTRD;
							end
							default: begin
								done_q <= 1'b1;
								dout_q <= rdata_q;
							end
						endcase
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (i_q != '0 && before_pv) begin
						i_q     <= parent;
						state_q <= (parent == '0) ? S_UPCMP : S_UPRD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ROOTRD: begin
					dout_q  <= rdata_q;
					state_q <= S_LASTRD;
				end
				S_LASTRD: begin
					v_q <= rdata_q;
					i_q <= '0;
					if (n_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DNRDL;
					end
				end
				S_DNRDL: begin
					has_r_q <= rchild < {1'b0, n_q};
					state_q <= S_DNRDR;
				end
				S_DNRDR: begin
					cl_q    <= rdata_q;
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					if ((lchild < {1'b0, n_q}) && before_cv) begin
						i_q     <= best_i;
						state_q <= S_DNRDL;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign dout = dout_q;
	assign size = size_q;

	`RMH_ASSERT_IMP(a_push_room, clk, arst_n, idle_start && op == OP_PUSH, size_q < SW'(CAP))
	`RMH_ASSERT_IMP(a_pop_nonempty, clk, arst_n, idle_start && op == OP_POP, size_q != '0)
	`RMH_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
endmodule

/* hw/rtl/running_median_two_heaps_core.sv */
//------------------------------------------------------------------------------
// running_median_two_heaps_core
// Running lower median over two memory-backed heaps.
//------------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall, action, value) takes one item
// at a time; each item yields exactly one result on the output channel
// (out_valid/out_stall, median, status, total_count).
// Action insert adds a value, pop removes the lower median, clear (action
// with the high bit set) empties both heaps.
// Clear, pop on empty and refused insert go to the output without a sift.
// A push sifts up one level per parent read and compare; a pop reads the
// root and the last entry, then sifts down one level per left read, right
// read and compare. An insert that needs a rebalance runs push, pop and
// push. The single read port of each heap memory and the level-by-level
// sift set how long an item takes.
// The next item can be taken in the cycle after the result is loaded.
// A result sits in an output register; the core takes the next item while
// it waits, but will not finish that item until the result is transferred.
// Reset empties both heaps at once; the memories need no clearing pass.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_median_two_heaps_core_macros.svh"
module running_median_two_heaps_core
	import rmh_pkg::*;
#(
	parameter int unsigned HEAP_CAPACITY = HEAP_CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             action,
	input  logic [IN_VALUE_W-1:0]  value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [IN_VALUE_W-1:0]  median,
	output logic [STATUS_W-1:0]    status,
	output logic [COUNT_W-1:0]     total_count
);
	localparam int unsigned SW = $clog2(HEAP_CAPACITY) + 1;
	localparam int unsigned VW = VALUE_WIDTH;
	localparam logic [SW:0] FULL_AT = (SW+1)'(2*HEAP_CAPACITY - 2);
	localparam logic [SW:0] BAL_GAP = (SW+1)'(2);

	typedef enum logic [6:0] {
		C_IDLE  = 7'b0000001,
		C_PEEK  = 7'b0000010,
		C_DEC   = 7'b0000100,
		C_WAIT1 = 7'b0001000,
		C_BAL   = 7'b0010000,
		C_WAIT2 = 7'b0100000,
		C_OUT   = 7'b1000000
	} cstate_t;

	cstate_t        state_q;
	logic [1:0]     act_q;
	logic [VW-1:0]  val_q;
	logic           mv_up_q;

	logic           u_start, l_start, u_done, l_done;
	heap_op_t       u_op, l_op;
	logic [VW-1:0]  u_din, l_din, u_dout, l_dout;
	logic [SW-1:0]  u_size, l_size;
	logic [SW:0]    u_ext, l_ext;
	logic [SW:0]    total;
	logic           up_heavy, lo_heavy;
	logic           clr;
	logic           out_load;

	logic                   ov_q;
	logic [IN_VALUE_W-1:0]  med_q;
	logic [STATUS_W-1:0]    st_q;
	logic [IN_VALUE_W-1:0]  res_med_q;
	logic [STATUS_W-1:0]    res_st_q;
	logic [COUNT_W-1:0]     res_cnt_q;

	assign u_ext    = {1'b0, u_size};
	assign l_ext    = {1'b0, l_size};
	assign total    = u_ext + l_ext;
	assign up_heavy = u_ext >= l_ext + BAL_GAP;
	assign lo_heavy = l_ext >= u_ext + BAL_GAP;
	assign clr      = (state_q == C_DEC) && act_q[1];
	assign out_load = (state_q == C_OUT) && (!ov_q || !out_stall);

	rmh_heap #(.CAP(HEAP_CAPACITY), .VW(VW), .IS_MAX(1'b0)) u_upper (
		.clk(clk), .arst_n(arst_n), .start(u_start), .op(u_op), .din(u_din),
		.clear(clr), .done(u_done), .dout(u_dout), .size(u_size)
	);
	rmh_heap #(.CAP(HEAP_CAPACITY), .VW(VW), .IS_MAX(1'b1)) u_lower (
		.clk(clk), .arst_n(arst_n), .start(l_start), .op(l_op), .din(l_din),
		.clear(clr), .done(l_done), .dout(l_dout), .size(l_size)
	);

	assign in_stall = (state_q != C_IDLE);

	// heap command decode
	always_comb begin
		u_start = 1'b0; u_op = OP_PEEK; u_din = val_q;
		l_start = 1'b0; l_op = OP_PEEK; l_din = val_q;
		case (state_q)
			C_PEEK: begin
				u_start = 1'b1;
			end
			C_DEC: begin
				if (!act_q[1] && act_q[0] && total != '0) begin
					if (u_size > l_size) begin
						u_start = 1'b1; u_op = OP_POP;
					end else begin
						l_start = 1'b1; l_op = OP_POP;
					end
				end else if (!act_q[1] && !act_q[0] && total < FULL_AT) begin
					if (u_size == '0 || val_q >= u_dout) begin
						u_start = 1'b1; u_op = OP_PUSH;
					end else begin
						l_start = 1'b1; l_op = OP_PUSH;
					end
				end
			end
			C_BAL: begin
				if (up_heavy) begin
					u_start = 1'b1; u_op = OP_POP;
				end else if (lo_heavy) begin
					l_start = 1'b1; l_op = OP_POP;
				end
			end
			C_WAIT2: begin
				if (mv_up_q && l_done) begin
					u_start = 1'b1; u_op = OP_PUSH; u_din = l_dout;
				end else if (!mv_up_q && u_done) begin
					l_start = 1'b1; l_op = OP_PUSH; l_din = u_dout;
				end
			end
			default: ;
		endcase
	end

	// item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						val_q   <= VW'(value);
						state_q <= C_PEEK;
					end
				end
				C_PEEK: state_q <= C_DEC;
				C_DEC: begin
					med_q <= '0;
					if (act_q[1]) begin
						st_q    <= ST_CLEARED;
						state_q <= C_OUT;
					end else if (act_q[0]) begin
						if (total == '0) begin
							st_q    <= ST_EMPTY;
							state_q <= C_OUT;
						end else begin
							st_q    <= ST_MEDIAN;
							state_q <= C_WAIT1;
						end
					end else if (total >= FULL_AT) begin
						st_q    <= ST_FULL;
						state_q <= C_OUT;
					end else begin
						st_q    <= ST_INSERTED;
						state_q <= C_WAIT1;
					end
				end
				// after the rebalance push the sizes are even, so C_BAL ends the item
				C_WAIT1: begin
					if (u_done || l_done) begin
						if (st_q == ST_MEDIAN) begin
							med_q   <= IN_VALUE_W'(u_done ? u_dout : l_dout);
							state_q <= C_OUT;
						end else begin
							state_q <= C_BAL;
						end
					end
				end
				C_BAL: begin
					if (up_heavy) begin
						mv_up_q <= 1'b0;
						state_q <= C_WAIT2;
					end else if (lo_heavy) begin
						mv_up_q <= 1'b1;
						state_q <= C_WAIT2;
					end else begin
						state_q <= C_OUT;
					end
				end
				C_WAIT2: begin
					if ((mv_up_q && l_done) || (!mv_up_q && u_done)) begin
						state_q <= C_WAIT1;
						st_q    <= ST_INSERTED;
						mv_up_q <= 1'b0;
						act_q   <= ACT_INSERT;
					end
				end
				C_OUT: begin
					if (!ov_q || !out_stall) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// result register: loads when free or when the waiting result transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q      <= 1'b0;
			res_med_q <= '0;
			res_st_q  <= '0;
			res_cnt_q <= '0;
		end else if (out_load) begin
			ov_q      <= 1'b1;
			res_med_q <= med_q;
			res_st_q  <= st_q;
			res_cnt_q <= COUNT_W'(total);
		end else if (ov_q && !out_stall) begin
			ov_q <= 1'b0;
		end
	end

	assign out_valid   = ov_q;
	assign median      = res_med_q;
	assign status      = res_st_q;
	assign total_count = res_cnt_q;

	`RMH_ASSERT_IMP(a_one_heap_busy, clk, arst_n, u_start, !l_start)
	`RMH_ASSERT_IMP(a_balanced_idle, clk, arst_n, state_q == C_IDLE, !up_heavy && !lo_heavy)
	`RMH_ASSERT_NEXT(a_out_hold, clk, arst_n, ov_q && out_stall, ov_q)
endmodule

/* sim/running_median_two_heaps_core_test.sv */
//------------------------------------------------------------------------------
// running_median_two_heaps_core_test
// Self-checking bench for the running median core. A directed table and then
// random insert/pop/clear traffic are driven over the valid/stall channel.
// Every transfer is checked against its typed table result, if given, or an
// in-bench pair of heaps that tracks the lower median, status and held count.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module running_median_two_heaps_core_test;
	import rmh_pkg::*;

	localparam int unsigned CAP       = HEAP_CAPACITY_DEF;
	localparam int unsigned FULL_LVL  = 2 * CAP - 2;
	localparam logic [1:0]  ACT_CLEAR = 2'd2;
	localparam logic [1:0]  ACT_CLR3  = 2'd3;
	localparam int          LO        = 0;   // max-heap, lower half
	localparam int          UP        = 1;   // min-heap, upper half
	localparam int          HOLD_CYC  = 400;

	typedef struct packed {
		logic [IN_VALUE_W-1:0] median;
		logic [STATUS_W-1:0]   status;
		logic [COUNT_W-1:0]    count;
	} median_result_t;

	typedef struct {
		logic [1:0]            act;
		logic [IN_VALUE_W-1:0] val;
		bit                    typed;
		median_result_t        res;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            action = ACT_INSERT;
	logic [IN_VALUE_W-1:0] value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [IN_VALUE_W-1:0] median;
	logic [STATUS_W-1:0]   status;
	logic [COUNT_W-1:0]    total_count;

	// shadow heaps
	logic [IN_VALUE_W-1:0] heap_mem [2][CAP];
	int unsigned           heap_n [2];

	median_result_t        median_q [$];
	bit                    drv_typed = 1'b0;
	median_result_t        drv_res;
	int unsigned           accept_cnt = 0;
	int unsigned           xfer_cnt = 0;
	int unsigned           err_cnt = 0;
	bit                    hold_req = 1'b0;
	bit                    no_idle = 1'b0;

	running_median_two_heaps_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.median     (median),
		.status     (status),
		.total_count(total_count)
	);

	always #5 clk = ~clk;

	// ordering within a heap: larger on top in the lower half, smaller in the upper
	function automatic bit sits_above(int h, logic [IN_VALUE_W-1:0] a,
			logic [IN_VALUE_W-1:0] b);
		return (h == LO) ? (a > b) : (a < b);
	endfunction

	function automatic void heap_push(int h, logic [IN_VALUE_W-1:0] v);
		int unsigned i, p;
		i = heap_n[h];
		heap_n[h]++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!sits_above(h, v, heap_mem[h][p]))
				break;
			heap_mem[h][i] = heap_mem[h][p];
			i = p;
		end
		heap_mem[h][i] = v;
	endfunction

	function automatic logic [IN_VALUE_W-1:0] heap_pop(int h);
		logic [IN_VALUE_W-1:0] top, v;
		int unsigned n, i, c;
		top = heap_mem[h][0];
		heap_n[h]--;
		n = heap_n[h];
		if (n == 0)
			return top;
		v = heap_mem[h][n];
		i = 0;
		forever begin
			c = 2 * i + 1;
			if (c >= n)
				break;
			if (c + 1 < n && sits_above(h, heap_mem[h][c + 1], heap_mem[h][c]))
				c++;
			if (!sits_above(h, heap_mem[h][c], v))
				break;
			heap_mem[h][i] = heap_mem[h][c];
			i = c;
		end
		heap_mem[h][i] = v;
		return top;
	endfunction

	// apply one item to the shadow heaps and return its result
	function automatic median_result_t predict_median_result(logic [1:0] act,
			logic [IN_VALUE_W-1:0] v);
		median_result_t r;
		int unsigned held;
		r = '0;
		held = heap_n[LO] + heap_n[UP];
		if (act[1]) begin
			heap_n[LO] = 0;
			heap_n[UP] = 0;
			r.status = ST_CLEARED;
		end else if (act == ACT_POP) begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.median = (heap_n[UP] > heap_n[LO]) ? heap_pop(UP) : heap_pop(LO);
				r.status = ST_MEDIAN;
			end
		end else if (held >= FULL_LVL) begin
			r.status = ST_FULL;
		end else begin
			if (heap_n[UP] == 0 || v >= heap_mem[UP][0])
				heap_push(UP, v);
			else
				heap_push(LO, v);
			if (heap_n[UP] >= heap_n[LO] + 2)
				heap_push(LO, heap_pop(UP));
			else if (heap_n[LO] >= heap_n[UP] + 2)
				heap_push(UP, heap_pop(LO));
			r.status = ST_INSERTED;
		end
		r.count = COUNT_W'(heap_n[LO] + heap_n[UP]);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [IN_VALUE_W-1:0] got,
			logic [IN_VALUE_W-1:0] want);
		$display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// transfer bookkeeping on both channels
	always @(posedge clk) begin
		median_result_t r, e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r = predict_median_result(action, value);
				median_q = {median_q, (drv_typed ? drv_res : r)};
				accept_cnt++;
			end
			if (out_valid && !out_stall) begin
				xfer_cnt++;
				if (median_q.size() == 0) begin
					report_mismatch("unexpected result", median, '0);
				end else begin
					e = median_q.pop_front();
					if (median !== e.median)
						report_mismatch("median", median, e.median);
					if (status !== e.status)
						report_mismatch("status", status, e.status);
					if (total_count !== e.count)
						report_mismatch("total_count", total_count, e.count);
				end
			end
		end
	end

	// output side: random stalls, with one long hold on request
	initial begin
		int n;
		int unsigned seen;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 12);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
				seen = xfer_cnt;
				while (seen == xfer_cnt && !hold_req)
					@(negedge clk);
			end
		end
	end

	// send one item; called and returns at a falling edge
	task automatic send_item(logic [1:0] act, logic [IN_VALUE_W-1:0] v, bit typed,
			median_result_t res);
		int gap;
		int unsigned start;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value <= v;
		drv_typed = typed;
		drv_res = res;
		start = accept_cnt;
		do
			@(negedge clk);
		while (start == accept_cnt);
	endtask

	function automatic logic [IN_VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] rand_action();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return ACT_INSERT;
		else if (p < 96)
			return ACT_POP;
		else if (p < 98)
			return ACT_CLEAR;
		return ACT_CLR3;
	endfunction

	task automatic drain_pause();
		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(negedge clk);
	endtask

	// directed rows; typed results only where obvious
	stim_row_t directed [] = '{
		'{ACT_POP,    32'h0,        1'b1, '{'0, ST_EMPTY,    11'd0}},
		'{ACT_INSERT, 32'h0,        1'b1, '{'0, ST_INSERTED, 11'd1}},
		'{ACT_INSERT, 32'hFFFFFFFF, 1'b1, '{'0, ST_INSERTED, 11'd2}},
		'{ACT_INSERT, 32'hFFFFFFFF, 1'b0, '0},
		'{ACT_INSERT, 32'h5,        1'b0, '0},
		'{ACT_INSERT, 32'h5,        1'b0, '0},
		'{ACT_POP,    32'h0,        1'b0, '0},
		'{ACT_POP,    32'hDEADBEEF, 1'b0, '0},
		'{ACT_CLEAR,  32'h0,        1'b1, '{'0, ST_CLEARED,  11'd0}},
		'{ACT_POP,    32'h0,        1'b1, '{'0, ST_EMPTY,    11'd0}},
		'{ACT_INSERT, 32'd10,       1'b0, '0},
		'{ACT_INSERT, 32'd20,       1'b0, '0},
		'{ACT_POP,    32'h0,        1'b0, '0},
		'{ACT_INSERT, 32'd3,        1'b0, '0},
		'{ACT_INSERT, 32'd1,        1'b0, '0},
		'{ACT_POP,    32'h0,        1'b0, '0},
		'{ACT_INSERT, 32'd25,       1'b0, '0},
		'{ACT_INSERT, 32'd20,       1'b0, '0},
		'{ACT_POP,    32'h0,        1'b0, '0},
		'{ACT_POP,    32'h0,        1'b0, '0},
		'{ACT_CLR3,   32'hA5A5A5A5, 1'b1, '{'0, ST_CLEARED,  11'd0}},
		'{ACT_INSERT, 32'h80000000, 1'b1, '{'0, ST_INSERTED, 11'd1}},
		'{ACT_POP,    32'h0,        1'b1, '{32'h80000000, ST_MEDIAN, 11'd1 - 11'd1}}
	};

	// main stimulus
	initial begin
		heap_n[LO] = 0;
		heap_n[UP] = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_item(directed[i].act, directed[i].val, directed[i].typed,
				directed[i].res);
		drain_pause();

		// random traffic with one long output hold and one burst without gaps
		for (int i = 0; i < 1200; i++) begin
			if (i == 300)
				hold_req = 1'b1;
			no_idle = (i >= 600 && i < 700);
			send_item(rand_action(), rand_value(), 1'b0, '0);
		end
		no_idle = 1'b0;
		send_item(ACT_INSERT, '1, 1'b0, '0);

		drain_pause();
		repeat (100) @(negedge clk);
		if (err_cnt == 0)
			$display("running_median_two_heaps_core_test: done, clean");
		else
			$display("running_median_two_heaps_core_test: done, errors");
		$finish;
	end

	// run limit
	initial begin
		#50ms;
		$display("running_median_two_heaps_core_test: done, errors");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rmh_pkg.sv
hw/rtl/rmh_heap.sv
hw/rtl/running_median_two_heaps_core.sv
sim/running_median_two_heaps_core_test.sv
